// ----- hdl/clr_pkg.sv -----
// shared constants and types of the clipped line rasterizer
// depends on nothing; used by clr_div and clipped_line_rasterizer
package clr_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int SCREEN_BITS_DEF = 12;

  // serial divider sizes for the default fraction and screen widths
  localparam int DIV_NUM_W = (34 + FRAC_BITS_DEF > SCREEN_BITS_DEF + 2 * FRAC_BITS_DEF + 1) ?
                             34 + FRAC_BITS_DEF : SCREEN_BITS_DEF + 2 * FRAC_BITS_DEF + 1;
  localparam int DIV_DEN_W = SCREEN_BITS_DEF + FRAC_BITS_DEF + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // region code bits
  localparam logic [3:0] RC_LEFT   = 4'd1;
  localparam logic [3:0] RC_RIGHT  = 4'd2;
  localparam logic [3:0] RC_BOTTOM = 4'd4;
  localparam logic [3:0] RC_TOP    = 4'd8;

  localparam logic CMD_LOAD = 1'b0;

  typedef enum logic [1:0] {
    ST_PIXEL  = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2,
    ST_NOLINE = 2'd3
  } status_e;

endpackage

// ----- hdl/clipped_line_rasterizer.sv -----
// top level of the clipped line rasterizer: sequencer, point registers, shared multiplier
// depends on clr_pkg and clr_div
//
// Usage: an item on the input channel is a load (cmd 0) or a step (cmd 1).
// A load clips the segment to [0,width] x [0,height] and returns one item
// with status accepted or rejected. Each step returns the next pixel of the
// active line, with last_pixel set on the final one; a step with no active
// line returns status 3. The window size (index 0 width, index 1 height)
// must be written over the config port only while the block is idle; the
// user is bound by this, and the block itself does not enforce it;
// cfg_ready_o is always high. A step passes through the states S_SMUL,
// S_STEP and S_PUSH. A load runs the serial divider once per clip round
// (up to four rounds) and once for the slope; NUM_W is the divider width
// (50 at the default sizes); the single radix-2 divider dominates a load.
// in_ready_o is high only while the sequencer is idle. A finished result is
// held in the output register; the next item can be taken while it waits,
// and the block stalls before writing the following result until the
// receiver takes it. Reset drops the active line and sets the window to
// 640 x 480.
module clipped_line_rasterizer #(
  parameter int FRAC_BITS   = clr_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_BITS = clr_pkg::SCREEN_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [clr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SCREEN_BITS-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic signed [15:0]            start_x_i,
  input  logic signed [15:0]            start_y_i,
  input  logic signed [15:0]            end_x_i,
  input  logic signed [15:0]            end_y_i,
  input  logic [7:0]                    red_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [SCREEN_BITS-1:0]        pixel_x_o,
  output logic [SCREEN_BITS-1:0]        pixel_y_o,
  output logic [7:0]                    red_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    blue_out_o,
  output logic                          last_pixel_o
);

  localparam int F     = FRAC_BITS;
  localparam int S     = SCREEN_BITS;
  localparam int PT_W  = F + 18;
  localparam int CL_W  = S + F + 1;
  localparam int POS_W = S + 1;
  localparam int A_W   = S + F + 2;
  localparam int B_W   = (F + 2 > 17) ? F + 2 : 17;
  localparam int P_W   = A_W + B_W;
  localparam int NUM_W = (34 + F > S + 2 * F + 1) ? 34 + F : S + 2 * F + 1;
  localparam int DEN_W = S + F + 1;
  localparam int FULL_W = ((S + 2 * F + 1 > P_W) ? S + 2 * F + 1 : P_W) + 1;
  localparam logic signed [FULL_W-1:0] MINOR_MAX = FULL_W'((1 << S) - 1);
  localparam logic [2:0] ROUNDS_MAX = 3'd4;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_CODE    = 12'b0000_0000_0010,
    S_TEST    = 12'b0000_0000_0100,
    S_CMUL    = 12'b0000_0000_1000,
    S_CDIV_GO = 12'b0000_0001_0000,
    S_CDIV    = 12'b0000_0010_0000,
    S_APPLY   = 12'b0000_0100_0000,
    S_SLOPE   = 12'b0000_1000_0000,
    S_SDIV    = 12'b0001_0000_0000,
    S_SMUL    = 12'b0010_0000_0000,
    S_STEP    = 12'b0100_0000_0000,
    S_PUSH    = 12'b1000_0000_0000
  } state_e;

  function automatic logic [3:0] region(input logic signed [PT_W-1:0] px,
                                        input logic signed [PT_W-1:0] py,
                                        input logic signed [PT_W-1:0] wlim,
                                        input logic signed [PT_W-1:0] hlim);
    logic [3:0] c;
    c = '0;
    if (px < 0) c = c | clr_pkg::RC_LEFT;
    else if (px > wlim) c = c | clr_pkg::RC_RIGHT;
    if (py < 0) c = c | clr_pkg::RC_BOTTOM;
    else if (py > hlim) c = c | clr_pkg::RC_TOP;
    return c;
  endfunction

  function automatic logic signed [PT_W-1:0] clampv(input logic signed [PT_W-1:0] v,
                                                    input logic signed [PT_W-1:0] hi);
    logic signed [PT_W-1:0] r;
    r = v;
    if (v < 0) r = '0;
    else if (v > hi) r = hi;
    return r;
  endfunction

  state_e state_q, state_d;

  logic [S-1:0] width_q, height_q;
  logic         line_active_q, line_active_d;
  logic         out_valid_q, out_valid_d;

  // line registers
  logic signed [15:0]     ox1_q, oy1_q, ox2_q, oy2_q;
  logic signed [PT_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [PT_W-1:0] x1_d, y1_d, x2_d, y2_d;
  logic [3:0]             c1_q, c2_q, co_q;
  logic                   upd1_q;
  logic [2:0]             round_q, round_d;
  logic [7:0]             red_q, green_q, blue_q;
  logic                   maj_x_q;
  logic [POS_W-1:0]       pos_q, pos_d, lim_q;
  logic signed [F+1:0]    slope_q;

  // shared multiplier and divider handles
  logic signed [A_W-1:0]  mul_a;
  logic signed [B_W-1:0]  mul_b;
  logic signed [P_W-1:0]  prod_d, prod_q;
  logic signed [16:0]     cden_q;
  logic                   qneg_q, qneg_d, qzero_q, qzero_d;
  logic                   div_start, div_done;
  logic [NUM_W-1:0]       div_num, div_quo;
  logic [DEN_W-1:0]       div_den;

  // pending result
  clr_pkg::status_e       res_status_q, res_status_d;
  logic [S-1:0]           res_x_q, res_x_d, res_y_q, res_y_d;
  logic                   res_last_q, res_last_d, res_pix_q, res_pix_d;

  // output register
  logic [1:0]             out_status_q;
  logic [S-1:0]           out_x_q, out_y_q;
  logic [7:0]             out_r_q, out_g_q, out_b_q;
  logic                   out_last_q;

  logic signed [PT_W-1:0] wf, hf;
  assign wf = $signed(PT_W'({width_q, {F{1'b0}}}));
  assign hf = $signed(PT_W'({height_q, {F{1'b0}}}));

  // clip round operands, original endpoints
  logic signed [16:0] dx_o, dy_o, ew, eh, ex0, ey0;
  logic               co_vert;
  assign dx_o    = 17'(ox2_q) - 17'(ox1_q);
  assign dy_o    = 17'(oy2_q) - 17'(oy1_q);
  assign ew      = $signed(17'(width_q)) - 17'(ox1_q);
  assign eh      = $signed(17'(height_q)) - 17'(oy1_q);
  assign ex0     = -17'(ox1_q);
  assign ey0     = -17'(oy1_q);
  assign co_vert = |(co_q & (clr_pkg::RC_TOP | clr_pkg::RC_BOTTOM));

  // slope setup from the clipped points
  logic signed [PT_W-1:0] dxp, dyp;
  logic [PT_W-1:0]        mx, my;
  logic                   maj_x;
  logic [PT_W-1:0]        a1, a2, alo, ahi;
  assign dxp   = x2_q - x1_q;
  assign dyp   = y2_q - y1_q;
  assign mx    = dxp[PT_W-1] ? PT_W'(-dxp) : PT_W'(dxp);
  assign my    = dyp[PT_W-1] ? PT_W'(-dyp) : PT_W'(dyp);
  assign maj_x = mx > my;
  assign a1    = maj_x ? x1_q : y1_q;
  assign a2    = maj_x ? x2_q : y2_q;
  assign alo   = (a1 > a2) ? a2 : a1;
  assign ahi   = (a1 > a2) ? a1 : a2;

  // signed quotient
  logic [PT_W-1:0]        qtr;
  logic signed [PT_W-1:0] qs;
  assign qtr = div_quo[PT_W-1:0];
  assign qs  = qzero_q ? '0 : (qneg_q ? -$signed(qtr) : $signed(qtr));

  logic [P_W-1:0] pabs;
  assign pabs = prod_q[P_W-1] ? P_W'(-prod_q) : P_W'(prod_q);

  // step arithmetic
  logic signed [PT_W-1:0]   om, on;
  logic signed [A_W-1:0]    off;
  logic signed [FULL_W-1:0] full, qf, qadj;
  logic [S-1:0]             minor;
  assign om   = maj_x_q ? x1_q : y1_q;
  assign on   = maj_x_q ? y1_q : x1_q;
  assign off  = $signed(A_W'({pos_q, {F{1'b0}}})) - A_W'(om);
  assign full = $signed(FULL_W'({on[CL_W-1:0], {F{1'b0}}})) + FULL_W'(prod_q);
  assign qf   = full >>> (2 * F);
  // truncate toward zero
  assign qadj = (full[FULL_W-1] && (|full[2*F-1:0])) ? qf + FULL_W'(1) : qf;
  always_comb begin
    if (qadj < 0) minor = '0;
    else if (qadj > MINOR_MAX) minor = MINOR_MAX[S-1:0];
    else minor = qadj[S-1:0];
  end

  always_comb begin
    mul_a = A_W'(off);
    mul_b = B_W'(slope_q);
    if (state_q == S_CMUL) begin
      mul_a = co_vert ? A_W'(dx_o) : A_W'(dy_o);
      if (|(co_q & clr_pkg::RC_TOP)) mul_b = B_W'(eh);
      else if (|(co_q & clr_pkg::RC_BOTTOM)) mul_b = B_W'(ey0);
      else if (|(co_q & clr_pkg::RC_RIGHT)) mul_b = B_W'(ew);
      else mul_b = B_W'(ex0);
    end
  end
  assign prod_d = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'({pabs[NUM_W-F-1:0], {F{1'b0}}});
    div_den   = DEN_W'(cden_q[16] ? 17'(-cden_q) : 17'(cden_q));
    qneg_d    = qneg_q;
    qzero_d   = qzero_q;
    if (state_q == S_CDIV_GO) begin
      div_start = 1'b1;
      qneg_d    = prod_q[P_W-1] ^ cden_q[16];
      qzero_d   = cden_q == '0;
    end else if (state_q == S_SLOPE) begin
      div_start = 1'b1;
      div_num   = maj_x ? NUM_W'({my[CL_W-1:0], {F{1'b0}}})
                        : NUM_W'({mx[CL_W-1:0], {F{1'b0}}});
      div_den   = maj_x ? DEN_W'(mx[CL_W-1:0]) : DEN_W'(my[CL_W-1:0]);
      qneg_d    = dxp[PT_W-1] ^ dyp[PT_W-1];
      qzero_d   = maj_x ? (mx == '0) : (my == '0);
    end
  end

  clr_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  logic in_take, out_load;
  assign in_ready_o = state_q == S_IDLE;
  assign in_take    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    line_active_d = line_active_q;
    round_d       = round_q;
    pos_d         = pos_q;
    x1_d          = x1_q;
    y1_d          = y1_q;
    x2_d          = x2_q;
    y2_d          = y2_q;
    res_status_d  = res_status_q;
    res_x_d       = res_x_q;
    res_y_d       = res_y_q;
    res_last_d    = res_last_q;
    res_pix_d     = res_pix_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          res_x_d    = '0;
          res_y_d    = '0;
          res_last_d = 1'b0;
          res_pix_d  = 1'b0;
          if (cmd_i == clr_pkg::CMD_LOAD) begin
            x1_d    = $signed(PT_W'(start_x_i)) <<< F;
            y1_d    = $signed(PT_W'(start_y_i)) <<< F;
            x2_d    = $signed(PT_W'(end_x_i)) <<< F;
            y2_d    = $signed(PT_W'(end_y_i)) <<< F;
            round_d = '0;
            state_d = S_CODE;
          end else if (!line_active_q) begin
            res_status_d = clr_pkg::ST_NOLINE;
            state_d      = S_PUSH;
          end else begin
            state_d = S_SMUL;
          end
        end
      end
      S_CODE: state_d = S_TEST;
      S_TEST: begin
        priority if (c1_q == '0 && c2_q == '0) begin
          state_d = S_SLOPE;
        end else if ((c1_q & c2_q) != '0) begin
          line_active_d = 1'b0;
          res_status_d  = clr_pkg::ST_REJECT;
          state_d       = S_PUSH;
        end else if (round_q == ROUNDS_MAX) begin
          // rounds used up: pull both points into the window
          x1_d    = clampv(x1_q, wf);
          y1_d    = clampv(y1_q, hf);
          x2_d    = clampv(x2_q, wf);
          y2_d    = clampv(y2_q, hf);
          state_d = S_SLOPE;
        end else begin
          round_d = round_q + 3'd1;
          state_d = S_CMUL;
        end
      end
      S_CMUL:    state_d = S_CDIV_GO;
      S_CDIV_GO: state_d = S_CDIV;
      S_CDIV: begin
        if (div_done) state_d = S_APPLY;
      end
      S_APPLY: begin
        logic signed [PT_W-1:0] nx, ny;
        nx = ($signed(PT_W'(ox1_q)) <<< F) + qs;
        ny = ($signed(PT_W'(oy1_q)) <<< F) + qs;
        if (|(co_q & clr_pkg::RC_TOP)) ny = hf;
        else if (|(co_q & clr_pkg::RC_BOTTOM)) ny = '0;
        else if (|(co_q & clr_pkg::RC_RIGHT)) nx = wf;
        else nx = '0;
        if (upd1_q) begin
          x1_d = nx;
          y1_d = ny;
        end else begin
          x2_d = nx;
          y2_d = ny;
        end
        state_d = S_CODE;
      end
      S_SLOPE: begin
        pos_d   = alo[F +: POS_W];
        state_d = S_SDIV;
      end
      S_SDIV: begin
        if (div_done) begin
          line_active_d = 1'b1;
          res_status_d  = clr_pkg::ST_ACCEPT;
          state_d       = S_PUSH;
        end
      end
      S_SMUL: state_d = S_STEP;
      S_STEP: begin
        res_status_d = clr_pkg::ST_PIXEL;
        res_pix_d    = 1'b1;
        res_x_d      = maj_x_q ? pos_q[S-1:0] : minor;
        res_y_d      = maj_x_q ? minor : pos_q[S-1:0];
        res_last_d   = pos_q >= lim_q;
        if (pos_q >= lim_q) line_active_d = 1'b0;
        else pos_d = pos_q + POS_W'(1);
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
      round_q       <= '0;
      width_q       <= S'(640);
      height_q      <= S'(480);
    end else begin
      state_q       <= state_d;
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
      round_q       <= round_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == clr_pkg::CFG_WIDTH) width_q <= cfg_data_i;
        else if (cfg_index_i == clr_pkg::CFG_HEIGHT) height_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q         <= x1_d;
    y1_q         <= y1_d;
    x2_q         <= x2_d;
    y2_q         <= y2_d;
    pos_q        <= pos_d;
    qneg_q       <= qneg_d;
    qzero_q      <= qzero_d;
    res_status_q <= res_status_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    res_last_q   <= res_last_d;
    res_pix_q    <= res_pix_d;
    if (in_take && cmd_i == clr_pkg::CMD_LOAD) begin
      ox1_q   <= start_x_i;
      oy1_q   <= start_y_i;
      ox2_q   <= end_x_i;
      oy2_q   <= end_y_i;
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
    end
    if (state_q == S_CODE) begin
      c1_q <= region(x1_q, y1_q, wf, hf);
      c2_q <= region(x2_q, y2_q, wf, hf);
    end
    if (state_q == S_TEST) begin
      co_q   <= (c1_q != '0) ? c1_q : c2_q;
      upd1_q <= c1_q != '0;
    end
    if (state_q == S_CMUL) begin
      cden_q <= co_vert ? dy_o : dx_o;
    end
    if (state_q == S_CMUL || state_q == S_SMUL) begin
      prod_q <= prod_d;
    end
    if (state_q == S_SLOPE) begin
      maj_x_q <= maj_x;
      lim_q   <= ahi[F +: POS_W];
    end
    if (state_q == S_SDIV && div_done) begin
      slope_q <= qs[F+1:0];
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
      out_r_q      <= res_pix_q ? red_q : 8'd0;
      out_g_q      <= res_pix_q ? green_q : 8'd0;
      out_b_q      <= res_pix_q ? blue_q : 8'd0;
      out_last_q   <= res_last_q;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign red_out_o    = out_r_q;
  assign green_out_o  = out_g_q;
  assign blue_out_o   = out_b_q;
  assign last_pixel_o = out_last_q;

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_CDIV || state_q == S_SDIV))
    else $error("divider finished outside a wait state");

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_q <= ROUNDS_MAX)
    else $error("clip round count past four");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !in_ready_o)
    else $error("ready right after taking an item");

endmodule

// ----- hdl/clr_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// depends on clr_pkg for default sizes
module clr_div #(
  parameter int NUM_W = clr_pkg::DIV_NUM_W,
  parameter int DEN_W = clr_pkg::DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_LOAD;
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_ONE;
      if (cnt_q == CNT_ONE) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- tb/tb.sv -----
// self-checking testbench of clipped_line_rasterizer: clip loads and pixel steps
// against an in-bench line model, under random idling and stalls and a fixed list of window sizes
// depends on clr_pkg and the rtl of clipped_line_rasterizer
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // register index with no register behind it
  localparam logic [clr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    clr_pkg::status_e status;
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } pixel_t;

  class raster_scoreboard;
    localparam longint ONE = 64'sd1 << 16;
    longint      win_w, win_h;
    bit          active, x_major;
    bit [12:0]   step_pos, step_end;
    longint      org_x, org_y, slope;
    logic [23:0] colour;
    pixel_t      pending_px[$];
    int          errors;

    function new();
      win_w = 640; win_h = 480; active = 0; x_major = 0;
      step_pos = 0; step_end = 0; org_x = 0; org_y = 0; slope = 0; colour = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [clr_pkg::CFG_IDX_W-1:0] idx, logic [11:0] val);
      if (idx == clr_pkg::CFG_WIDTH) win_w = val;
      else if (idx == clr_pkg::CFG_HEIGHT) win_h = val;
    endfunction

    function longint div0(longint n, longint d);
      if (d == 0) return 0;
      return n / d;
    endfunction

    function longint sat(longint v, longint hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function longint absv(longint v);
      return v < 0 ? -v : v;
    endfunction

    function logic [3:0] outcode(longint x, longint y, longint wf, longint hf);
      logic [3:0] c;
      c = 0;
      if (x < 0) c |= clr_pkg::RC_LEFT;
      else if (x > wf) c |= clr_pkg::RC_RIGHT;
      if (y < 0) c |= clr_pkg::RC_BOTTOM;
      else if (y > hf) c |= clr_pkg::RC_TOP;
      return c;
    endfunction

    function clr_pkg::status_e clip_line(longint ax, longint ay, longint bx, longint by,
                                         logic [23:0] rgb);
      longint wf, hf, x1, y1, x2, y2, x, y, dx, dy;
      logic [3:0] c1, c2, co;
      int rounds;
      bit [63:0] a1, a2, t;
      wf = win_w * ONE; hf = win_h * ONE;
      x1 = ax * ONE; y1 = ay * ONE; x2 = bx * ONE; y2 = by * ONE;
      c1 = outcode(x1, y1, wf, hf); c2 = outcode(x2, y2, wf, hf);
      rounds = 0;
      forever begin
        if (c1 == 0 && c2 == 0) break;
        if ((c1 & c2) != 0) begin
          active = 0;
          return clr_pkg::ST_REJECT;
        end
        if (rounds == 4) begin
          x1 = sat(x1, wf); y1 = sat(y1, hf); x2 = sat(x2, wf); y2 = sat(y2, hf);
          break;
        end
        rounds++;
        co = (c1 != 0) ? c1 : c2;
        if ((co & clr_pkg::RC_TOP) != 0) begin
          x = ax * ONE + div0((bx - ax) * (win_h - ay) * ONE, by - ay); y = hf;
        end else if ((co & clr_pkg::RC_BOTTOM) != 0) begin
          x = ax * ONE + div0((bx - ax) * (0 - ay) * ONE, by - ay); y = 0;
        end else if ((co & clr_pkg::RC_RIGHT) != 0) begin
          y = ay * ONE + div0((by - ay) * (win_w - ax) * ONE, bx - ax); x = wf;
        end else begin
          y = ay * ONE + div0((by - ay) * (0 - ax) * ONE, bx - ax); x = 0;
        end
        if (co == c1) begin
          x1 = x; y1 = y; c1 = outcode(x1, y1, wf, hf);
        end else begin
          x2 = x; y2 = y; c2 = outcode(x2, y2, wf, hf);
        end
      end
      dx = x2 - x1; dy = y2 - y1;
      org_x = x1; org_y = y1;
      if (absv(dx) > absv(dy)) begin
        x_major = 1; slope = div0(dy * ONE, dx); a1 = x1; a2 = x2;
      end else begin
        x_major = 0; slope = (dy == 0) ? 0 : div0(dx * ONE, dy); a1 = y1; a2 = y2;
      end
      if (a1 > a2) begin
        t = a1; a1 = a2; a2 = t;
      end
      step_pos = a1[28:16]; step_end = a2[28:16];
      colour = rgb; active = 1;
      return clr_pkg::ST_ACCEPT;
    endfunction

    // works out the result of one accepted item and queues it
    function void note_item(logic cmd, logic signed [15:0] sx, logic signed [15:0] sy,
                            logic signed [15:0] ex, logic signed [15:0] ey,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t p;
      longint om, on, off, full, minor;
      p = '{clr_pkg::ST_PIXEL, 0, 0, 0, 0, 0, 0};
      if (cmd == clr_pkg::CMD_LOAD) begin
        p.status = clip_line(sx, sy, ex, ey, {r, g, b});
      end else if (!active) begin
        p.status = clr_pkg::ST_NOLINE;
      end else begin
        om = x_major ? org_x : org_y;
        on = x_major ? org_y : org_x;
        off = longint'({51'd0, step_pos}) * ONE - om;
        full = on * ONE + off * slope;
        minor = sat(div0(full, ONE * ONE), 4095);
        p.px = x_major ? step_pos[11:0] : minor[11:0];
        p.py = x_major ? minor[11:0] : step_pos[11:0];
        {p.red, p.green, p.blue} = colour;
        p.last = step_pos >= step_end;
        if (p.last) active = 0;
        else step_pos = step_pos + 1;
      end
      pending_px.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, got.status);
        errors++;
        return;
      end
      want = pending_px.pop_front();
      if (got.status != want.status || got.px != want.px || got.py != want.py ||
          got.red != want.red || got.green != want.green || got.blue != want.blue ||
          got.last != want.last) begin
        $display("%0t: mismatch expected st=%0d x=%0d y=%0d rgb=%h%h%h last=%0d",
                 $time, want.status, want.px, want.py, want.red, want.green,
                 want.blue, want.last);
        $display("%0t:          actual   st=%0d x=%0d y=%0d rgb=%h%h%h last=%0d",
                 $time, got.status, got.px, got.py, got.red, got.green,
                 got.blue, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [clr_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [11:0] cfg_data_i;
  logic in_valid_i, in_ready_o, cmd_i;
  logic signed [15:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic [7:0] red_in_i, green_in_i, blue_in_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] status_o;
  logic [11:0] pixel_x_o, pixel_y_o;
  logic [7:0] red_out_o, green_out_o, blue_out_o;
  logic last_pixel_o;

  clipped_line_rasterizer dut (.*);

  raster_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int cur_w = 640, cur_h = 480;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // monitors
  always @(posedge clk_i) begin
    pixel_t got;
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_item(cmd_i, start_x_i, start_y_i, end_x_i, end_y_i,
                   red_in_i, green_in_i, blue_in_i);
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = clr_pkg::status_e'(status_o);
      got.px = pixel_x_o; got.py = pixel_y_o;
      got.red = red_out_o; got.green = green_out_o; got.blue = blue_out_o;
      got.last = last_pixel_o;
      sb.check_pixel(got);
    end
  end

  // watchdog on cycles without any handshake on the input, output or config port
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: stall pattern is redrawn periodically, with one long hold-off
  initial begin
    int cyc, mode, hold;
    cyc = 0; mode = 0; hold = 0;
    out_ready_i = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 300 == 0) mode = $urandom_range(0, 3);
      if (cyc == 8000) hold = 900;
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send(logic cmd, int sx, int sy, int ex, int ey);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    start_x_i <= sx; start_y_i <= sy; end_x_i <= ex; end_y_i <= ey;
    red_in_i <= $urandom; green_in_i <= $urandom; blue_in_i <= $urandom;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic step_n(int n);
    repeat (n) send(1'b1, $urandom, $urandom, $urandom, $urandom);
  endtask

  // waits out the block before a register write
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_window(int w, int h);
    cfg_valid_i <= 1'b1; cfg_index_i <= clr_pkg::CFG_WIDTH; cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= clr_pkg::CFG_HEIGHT; cfg_data_i <= h;
    do @(posedge clk_i); while (!cfg_ready_o);
    // unused index must be ignored
    cfg_index_i <= CFG_UNUSED; cfg_data_i <= $urandom;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_w = w; cur_h = h;
  endtask

  function automatic int near_coord(int lim);
    int m;
    m = $urandom_range(0, 3) == 0 ? 2000 : 20;
    return $urandom_range(0, lim + 2 * m) - m;
  endfunction

  initial begin
    int wl[6], hl[6], target, m;
    wl = '{640, 1, 4095, 37, 4095, 1};
    hl = '{480, 1, 4095, 23, 1, 4095};
    rst_ni = 0; cfg_valid_i = 0; cfg_index_i = clr_pkg::CFG_WIDTH; cfg_data_i = 0;
    in_valid_i = 0; cmd_i = 1; start_x_i = 0; start_y_i = 0; end_x_i = 0; end_y_i = 0;
    red_in_i = 0; green_in_i = 0; blue_in_i = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: no line, extremes, rejects, straight lines, single point
    step_n(1);
    send(clr_pkg::CMD_LOAD, -32768, -32768, 32767, 32767); step_n(3);
    send(clr_pkg::CMD_LOAD, 32767, -32768, -32768, 32767); step_n(2);
    send(clr_pkg::CMD_LOAD, -5, -5, -1, 700);
    send(clr_pkg::CMD_LOAD, 700, 10, 900, 400); step_n(1);
    send(clr_pkg::CMD_LOAD, 10, 20, 10, 25); step_n(7);
    send(clr_pkg::CMD_LOAD, 3, 7, 9, 7); step_n(4);
    send(clr_pkg::CMD_LOAD, 100, 100, 100, 100); step_n(2);
    send(clr_pkg::CMD_LOAD, -20, 470, 30, 520); step_n(3);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        write_window(wl[ph], hl[ph]);
      end
      target = (ph + 1) * 1550 / 6;
      while (items_sent < target) begin
        m = $urandom_range(0, 9);
        if (m == 0)
          send(clr_pkg::CMD_LOAD, $urandom, $urandom, $urandom, $urandom);
        else
          send(clr_pkg::CMD_LOAD, near_coord(cur_w), near_coord(cur_h),
               near_coord(cur_w), near_coord(cur_h));
        step_n($urandom_range(0, 7) == 0 ? $urandom_range(30, 70) : $urandom_range(0, 12));
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_px.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
